// ===== src/sblru_pkg.sv =====
// Shared types and constants for the size-bounded LRU cache.
package sblru_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF   = 24;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned ESIZE_W         = 24;
  localparam int unsigned BYTES_W         = 32;

  localparam logic [BYTES_W-1:0] CAP_RESET = 32'd6000000;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [KEY_W-1:0]   key;
    logic [ESIZE_W-1:0] entry_size;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
    logic [ESIZE_W-1:0] evicted_size;
    logic [BYTES_W-1:0] used_bytes;
    logic [BYTES_W-1:0] highwater_bytes;
    logic               last;
  } out_item_t;

endpackage

// ===== src/sblru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sblru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/size_bounded_lru_cache_core.sv =====
// Top level of the size-bounded LRU cache: sequencer, byte totals and entry RAM.
//
// Size-bounded LRU cache. Entries (key, byte size) sit in a RAM ordered by
// recency, slot 0 most recent. An item is taken when start is high and busy
// is low; busy stays high until the item's final result has been issued.
// Results appear on out_data for exactly one cycle with out_valid high and
// cannot be held off, so the receiver must take every strobe. An insert
// gives one result per eviction and then a final result with last set; all
// other commands give one result with last set. Clear and the unused command
// answer in the cycle after acceptance with busy staying low. All work goes
// through the single entry RAM port pair:
//   lookup: reads slots from 0, comparing each with the key; on a hit at
//           recency slot p, the younger entries shift down one slot,
//           then the head write and the final result follow. A miss
//           reads all n held entries, then gives the final result.
//   insert: each eviction reads the tail and issues its result; then the
//           fit is checked, the n remaining entries shift, the new one is
//           placed at the front and the final result is issued.
// The fit test uses the exact byte total; reported totals saturate at
// 32 bits. The capacity register is written over cfg_valid/cfg_ready, which
// is always ready; write it only while no item is in flight.
module size_bounded_lru_cache_core
  import sblru_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned SIZE_BITS   = SIZE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_data,
  output logic               out_valid,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BYTES_W-1:0] cfg_data
);

  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ENT_W = KEY_W + SIZE_BITS;
  // exact byte total never exceeds MAX_ENTRIES * (2^SIZE_BITS - 1)
  localparam int unsigned SW    = SIZE_BITS + CW;
  localparam int unsigned TW    = ((SW > BYTES_W) ? SW : BYTES_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_EVCHK,
    S_EVOUT,
    S_SHIFT,
    S_HEAD,
    S_FIN
  } state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [SW-1:0]        sum_r;
  logic [BYTES_W-1:0]   hw_r;
  logic [BYTES_W-1:0]   cap_r;
  logic                 is_ins_r;
  logic [KEY_W-1:0]     key_r;
  logic [KEY_W-1:0]     hkey_r;      // entry placed at the head
  logic [SIZE_BITS-1:0] hsize_r;
  logic [CW-1:0]        rp_r;        // next slot to read in search
  logic                 cv_r;        // read data valid for compare
  logic [AW-1:0]        ci_r;        // slot of the data under compare
  logic [AW-1:0]        src_r;       // next shift source
  logic                 rd_left_r;
  logic                 wv_r;        // shift write pending
  logic [AW-1:0]        dst_r;
  logic                 out_valid_r;
  out_item_t            out_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [ENT_W-1:0]     ram_rdata;

  logic [KEY_W-1:0]     rd_key;
  logic [SIZE_BITS-1:0] rd_size;
  logic [SIZE_BITS-1:0] nsz;
  logic                 hit_now;
  logic                 search_rd;
  logic                 full;
  logic                 over;
  logic                 evict_now;
  logic [SW-1:0]        sum_less;
  logic [BYTES_W-1:0]   used_now;

  function automatic logic [BYTES_W-1:0] sat32(input logic [TW-1:0] v);
    sat32 = (v > TW'({BYTES_W{1'b1}})) ? {BYTES_W{1'b1}} : v[BYTES_W-1:0];
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rd_key    = ram_rdata[ENT_W-1 -: KEY_W];
  assign rd_size   = ram_rdata[SIZE_BITS-1:0];
  assign nsz       = SIZE_BITS'(in_data.entry_size);

  assign hit_now   = (state_r == S_SEARCH) && cv_r && (rd_key == key_r);
  assign search_rd = (rp_r < count_r) && !hit_now;
  assign full      = (count_r == CW'(MAX_ENTRIES));
  // fit test on the exact total
  assign over      = (TW'(sum_r) + TW'(hsize_r)) > TW'(cap_r);
  assign evict_now = (count_r != '0) && (over || full);
  assign sum_less  = sum_r - SW'(rd_size);
  assign used_now  = sat32(TW'(sum_r));

  // RAM port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    unique case (state_r)
      S_SEARCH: begin
        ram_re    = search_rd;
        ram_raddr = rp_r[AW-1:0];
      end
      S_EVCHK: begin
        ram_re    = evict_now;
        ram_raddr = AW'(count_r - CW'(1));
      end
      S_SHIFT: begin
        ram_re    = rd_left_r;
        ram_raddr = src_r;
        ram_we    = wv_r;
        ram_waddr = dst_r;
      end
      S_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {hkey_r, hsize_r};
      end
      default: begin
      end
    endcase
  end

  sblru_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      hw_r        <= '0;
      cap_r       <= CAP_RESET;
      cv_r        <= 1'b0;
      wv_r        <= 1'b0;
      rd_left_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            key_r    <= in_data.key;
            hkey_r   <= in_data.key;
            hsize_r  <= nsz;
            is_ins_r <= (in_data.cmd == CMD_INSERT);
            unique case (in_data.cmd)
              CMD_LOOKUP: begin
                rp_r    <= '0;
                cv_r    <= 1'b0;
                state_r <= S_SEARCH;
              end
              CMD_INSERT: begin
                state_r <= S_EVCHK;
              end
              CMD_CLEAR: begin
                count_r     <= '0;
                sum_r       <= '0;
                out_valid_r <= 1'b1;
                out_r       <= '{hit: 1'b0, evicted: 1'b0, evicted_key: '0,
                                 evicted_size: '0, used_bytes: '0,
                                 highwater_bytes: hw_r, last: 1'b1};
              end
              default: begin
                // unused command: report totals, change nothing
                out_valid_r <= 1'b1;
                out_r       <= '{hit: 1'b0, evicted: 1'b0, evicted_key: '0,
                                 evicted_size: '0, used_bytes: used_now,
                                 highwater_bytes: hw_r, last: 1'b1};
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (hit_now) begin
            hkey_r    <= rd_key;
            hsize_r   <= rd_size;
            src_r     <= ci_r - AW'(1);
            rd_left_r <= (ci_r != '0);
            wv_r      <= 1'b0;
            cv_r      <= 1'b0;
            state_r   <= S_SHIFT;
          end else if (search_rd) begin
            cv_r <= 1'b1;
            ci_r <= rp_r[AW-1:0];
            rp_r <= rp_r + CW'(1);
          end else begin
            cv_r <= 1'b0;
            if (!cv_r) begin
              out_valid_r <= 1'b1;
              out_r       <= '{hit: 1'b0, evicted: 1'b0, evicted_key: '0,
                               evicted_size: '0, used_bytes: used_now,
                               highwater_bytes: hw_r, last: 1'b1};
              state_r     <= S_IDLE;
            end
          end
        end
        S_EVCHK: begin
          if (evict_now) begin
            state_r <= S_EVOUT;
          end else begin
            // list is below full here; count-1 is the tail slot unless the list is empty
            src_r     <= AW'(count_r - CW'(1));
            rd_left_r <= (count_r != '0);
            wv_r      <= 1'b0;
            state_r   <= S_SHIFT;
          end
        end
        S_EVOUT: begin
          count_r     <= count_r - CW'(1);
          sum_r       <= sum_less;
          out_valid_r <= 1'b1;
          out_r       <= '{hit: 1'b0, evicted: 1'b1, evicted_key: rd_key,
                           evicted_size: ESIZE_W'(rd_size),
                           used_bytes: sat32(TW'(sum_less)),
                           highwater_bytes: hw_r, last: 1'b0};
          state_r     <= S_EVCHK;
        end
        S_SHIFT: begin
          // read slot src while writing the previous read to the slot after its own
          if (rd_left_r) begin
            wv_r  <= 1'b1;
            dst_r <= src_r + AW'(1);
            if (src_r == '0) begin
              rd_left_r <= 1'b0;
            end else begin
              src_r <= src_r - AW'(1);
            end
          end else begin
            wv_r    <= 1'b0;
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (is_ins_r) begin
            count_r <= count_r + CW'(1);
            sum_r   <= sum_r + SW'(hsize_r);
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_r       <= '{hit: !is_ins_r, evicted: 1'b0, evicted_key: '0,
                           evicted_size: '0, used_bytes: used_now,
                           highwater_bytes: (used_now > hw_r) ? used_now : hw_r,
                           last: 1'b1};
          if (used_now > hw_r) begin
            hw_r <= used_now;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/sblru_chk.sv =====
// Port-level checker for the LRU cache core, bound to the top level.
module sblru_chk
  import sblru_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  // an eviction is never the final result and never a hit
  a_evict_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> !out_data.hit && !out_data.last)
    else $error("eviction result marked hit or last");

  // more results follow an eviction, so the core stays busy
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> busy)
    else $error("core idle while an item still has results to give");

  // high-water mark covers the current total
  a_hw_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.highwater_bytes >= out_data.used_bytes)
    else $error("highwater below used bytes");

  // an accepted item either keeps the core busy or answers at once
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted item neither started nor answered");

endmodule

bind size_bounded_lru_cache_core sblru_chk u_sblru_chk (.*);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the size-bounded LRU cache core.
module tb_top;
  import sblru_pkg::*;

  // Bench constants: cache depth, phase sizes, the watchdog bound and the drain time.
  localparam int unsigned DEPTH        = MAX_ENTRIES_DEF;
  localparam logic [1:0]  CMD_RESERVED = 2'd3;   // unused opcode, block only reports totals
  localparam int          PHASES       = 6;
  localparam int          PHASE_ITEMS  = 60;
  localparam int          STALL_LIMIT  = 1000;   // cycles with no handshake of any kind
  localparam int          DRAIN_CYCLES = 64;     // longer than a full 16-eviction insert
  localparam int          PRINT_CAP    = 40;

  typedef struct packed {
    in_item_t  item;
    logic      typed;    // expected result written into the row, single result only
    out_item_t result;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_data;
  logic               out_valid;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [BYTES_W-1:0] cfg_data;

  size_bounded_lru_cache_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predicted cache contents. Slot 0 is most recent. Updated at the edge where
  // an item is taken, so it always runs ahead of the results still in flight.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]   lru_keys  [DEPTH];
  logic [ESIZE_W-1:0] lru_sizes [DEPTH];
  int unsigned        lru_count    = 0;
  logic [BYTES_W-1:0] lru_used     = '0;
  logic [BYTES_W-1:0] lru_peak     = '0;
  logic [BYTES_W-1:0] lru_capacity = CAP_RESET;

  out_item_t pending_results[$];   // results owed by the block, oldest first
  dir_row_t  dir_rows[$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int hits_seen      = 0;
  int evictions_seen = 0;
  int cap_writes     = 0;
  int idle_count     = 0;
  out_item_t mon_want;

  function automatic out_item_t mk_result(logic hit, logic ev, logic [KEY_W-1:0] ek,
                                          logic [ESIZE_W-1:0] es, logic [BYTES_W-1:0] used,
                                          logic [BYTES_W-1:0] peak, logic last);
    out_item_t r;
    r.hit             = hit;
    r.evicted         = ev;
    r.evicted_key     = ek;
    r.evicted_size    = es;
    r.used_bytes      = used;
    r.highwater_bytes = peak;
    r.last            = last;
    return r;
  endfunction

  // Exact byte total of held entries; the fit test must not wrap.
  function automatic logic [63:0] held_bytes();
    logic [63:0] total;
    int unsigned i;
    total = '0;
    for (i = 0; i < lru_count; i++) total += 64'(lru_sizes[i]);
    return total;
  endfunction

  function automatic logic [BYTES_W-1:0] sat_bytes(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? '1 : v[BYTES_W-1:0];
  endfunction

  // Work out every result an item causes and queue them in order.
  function automatic void predict_cache_results(in_item_t it);
    logic [KEY_W-1:0]   k;
    logic [ESIZE_W-1:0] sz;
    int                 idx;
    int                 i;
    int unsigned        t;
    case (it.cmd)
      CMD_LOOKUP: begin
        idx = -1;
        for (i = 0; i < int'(lru_count); i++)
          if (idx < 0 && lru_keys[i] == it.key) idx = i;
        if (idx >= 0) begin
          // hit: rotate the matching slot up to the front
          k  = lru_keys[idx];
          sz = lru_sizes[idx];
          for (i = idx; i > 0; i--) begin
            lru_keys[i]  = lru_keys[i-1];
            lru_sizes[i] = lru_sizes[i-1];
          end
          lru_keys[0]  = k;
          lru_sizes[0] = sz;
        end
        pending_results.push_back(mk_result(idx >= 0, 1'b0, '0, '0, lru_used, lru_peak, 1'b1));
      end
      CMD_INSERT: begin
        sz = it.entry_size;
        // evict from the tail while over budget or while the list is full
        while (lru_count > 0 &&
               (held_bytes() + 64'(sz) > 64'(lru_capacity) || lru_count >= DEPTH)) begin
          t         = lru_count - 1;
          lru_count = t;
          lru_used  = sat_bytes(held_bytes());
          pending_results.push_back(mk_result(1'b0, 1'b1, lru_keys[t], lru_sizes[t],
                                              lru_used, lru_peak, 1'b0));
        end
        for (i = int'(lru_count); i > 0; i--) begin
          lru_keys[i]  = lru_keys[i-1];
          lru_sizes[i] = lru_sizes[i-1];
        end
        lru_keys[0]  = it.key;
        lru_sizes[0] = sz;
        lru_count++;
        lru_used = sat_bytes(held_bytes());
        if (lru_used > lru_peak) lru_peak = lru_used;
        pending_results.push_back(mk_result(1'b0, 1'b0, '0, '0, lru_used, lru_peak, 1'b1));
      end
      CMD_CLEAR: begin
        lru_count = 0;
        lru_used  = '0;
        pending_results.push_back(mk_result(1'b0, 1'b0, '0, '0, lru_used, lru_peak, 1'b1));
      end
      default: begin
        pending_results.push_back(mk_result(1'b0, 1'b0, '0, '0, lru_used, lru_peak, 1'b1));
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor: a strobe is taken at the edge that ends its cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (out_data.hit === 1'b1) hits_seen++;
      if (out_data.evicted === 1'b1) evictions_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        mon_want = pending_results.pop_front();
        check_field("hit",             32'(out_data.hit),          32'(mon_want.hit));
        check_field("evicted",         32'(out_data.evicted),      32'(mon_want.evicted));
        check_field("evicted_key",     out_data.evicted_key,       mon_want.evicted_key);
        check_field("evicted_size",    32'(out_data.evicted_size), 32'(mon_want.evicted_size));
        check_field("used_bytes",      out_data.used_bytes,        mon_want.used_bytes);
        check_field("highwater_bytes", out_data.highwater_bytes,   mon_want.highwater_bytes);
        check_field("last",            32'(out_data.last),         32'(mon_want.last));
      end
    end
  end

  // Watchdog: any handshake on any channel restarts the count.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Hold start with the item until an edge sees busy low; start stays high on return.
  task automatic send_item(in_item_t it);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predict_cache_results(it);
    items_sent++;
  endtask

  // Drop start and wait for the block to go quiet with nothing owed.
  task automatic pause_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_capacity(logic [BYTES_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    lru_capacity = value;
    cap_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Mostly back-to-back or short gaps, now and then a long one.
  task automatic sender_gap(bit burst);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (burst || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic add_row(logic [1:0] cmd, logic [KEY_W-1:0] key, logic [ESIZE_W-1:0] sz,
                         logic typed, out_item_t result);
    dir_row_t row;
    row.item.cmd        = cmd;
    row.item.key        = key;
    row.item.entry_size = sz;
    row.typed           = typed;
    row.result          = result;
    dir_rows.push_back(row);
  endtask

  // Random item: keys mostly from a small pool or from what is held, so that
  // lookups hit at every recency slot; some sizes are scaled to the current budget.
  function automatic in_item_t rand_item();
    in_item_t    it;
    int          r;
    logic [63:0] clip;
    r = $urandom_range(0, 99);
    if (r < 45) it.cmd = CMD_LOOKUP;
    else if (r < 88) it.cmd = CMD_INSERT;
    else if (r < 94) it.cmd = CMD_CLEAR;
    else it.cmd = CMD_RESERVED;

    r = $urandom_range(0, 99);
    if (r < 35 && lru_count > 0) it.key = lru_keys[$urandom_range(0, lru_count - 1)];
    else if (r < 80) it.key = 32'($urandom_range(0, 23)) * 32'h0B00_B135;
    else if (r < 85) it.key = (r[0]) ? '1 : '0;
    else it.key = $urandom;

    r = $urandom_range(0, 99);
    clip = 64'(lru_capacity) / 64'($urandom_range(2, 12));
    if (clip > 64'hFF_FFFF) clip = 64'hFF_FFFF;
    if (r < 45) it.entry_size = ESIZE_W'($urandom_range(0, 32'(clip)));
    else if (r < 65) it.entry_size = ESIZE_W'($urandom_range(0, 255));
    else if (r < 85) it.entry_size = ESIZE_W'($urandom);
    else if (r < 93) it.entry_size = '0;
    else it.entry_size = '1;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [BYTES_W-1:0] caps [PHASES];
    bit                 burst;
    int                 p;
    int                 n;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset budget of 6000000 bytes.
    // empty cache: miss, unused opcode, clear and a zero-size insert all report zeros
    add_row(CMD_LOOKUP,   32'h0,        24'h0,      1'b1,
            mk_result(1'b0, 1'b0, '0, '0, '0, '0, 1'b1));
    add_row(CMD_RESERVED, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1,
            mk_result(1'b0, 1'b0, '0, '0, '0, '0, 1'b1));
    add_row(CMD_CLEAR,    32'h0,        24'h0,      1'b1,
            mk_result(1'b0, 1'b0, '0, '0, '0, '0, 1'b1));
    add_row(CMD_INSERT,   32'h0,        24'h0,      1'b1,
            mk_result(1'b0, 1'b0, '0, '0, '0, '0, 1'b1));
    // largest entry: evicts the empty one, then sits alone over budget
    add_row(CMD_INSERT,   32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, '0);
    add_row(CMD_LOOKUP,   32'hFFFF_FFFF, 24'h0,     1'b1,
            mk_result(1'b1, 1'b0, '0, '0, 32'hFF_FFFF, 32'hFF_FFFF, 1'b1));
    add_row(CMD_INSERT,   32'd1,        24'd1000,   1'b0, '0);
    // duplicate key: lookup must find the newer copy
    add_row(CMD_INSERT,   32'd2,        24'd2000000, 1'b0, '0);
    add_row(CMD_INSERT,   32'd2,        24'd3000000, 1'b0, '0);
    add_row(CMD_LOOKUP,   32'd2,        24'h0,      1'b0, '0);
    add_row(CMD_LOOKUP,   32'd1,        24'hFF_FFFF, 1'b0, '0);
    add_row(CMD_LOOKUP,   32'd5,        24'h0,      1'b0, '0);
    // just over budget by 1000 bytes: one tail eviction
    add_row(CMD_INSERT,   32'd3,        24'd1000000, 1'b0, '0);
    add_row(CMD_LOOKUP,   32'd2,        24'h0,      1'b0, '0);
    add_row(CMD_INSERT,   32'hAAAA_AAAA, 24'h55_5555, 1'b0, '0);
    add_row(CMD_INSERT,   32'h5555_5555, 24'hAA_AAAA, 1'b0, '0);
    add_row(CMD_RESERVED, 32'h0,        24'h0,      1'b0, '0);
    // clear keeps the peak
    add_row(CMD_CLEAR,    32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, '0);
    add_row(CMD_LOOKUP,   32'h5555_5555, 24'h0,     1'b0, '0);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item);
      if (dir_rows[i].typed) begin
        // typed rows cause one result; the hand-written value replaces the predicted one
        void'(pending_results.pop_back());
        pending_results.push_back(dir_rows[i].result);
      end
      sender_gap(1'b0);
    end
    pause_until_drained();

    // Budgets per phase: both extremes, a tiny one, the reset value and two random.
    caps[0] = '1;        // only the entry limit forces evictions
    caps[1] = '0;        // any insert that would make the total nonzero flushes the list
    caps[2] = 32'd1000;
    caps[3] = 32'($urandom_range(1, 50_000_000));
    caps[4] = CAP_RESET;
    caps[5] = $urandom;

    for (p = 0; p < PHASES; p++) begin
      write_capacity(caps[p]);
      burst = 1'b0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 10 == 0) burst = ($urandom_range(0, 3) == 0);
        send_item(rand_item());
        if ($urandom_range(0, 39) == 0) pause_until_drained();
        else sender_gap(burst);
      end
      pause_until_drained();
    end

    // Anything arriving now is a stray result and the monitor flags it.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items over %0d budget settings: %0d results, %0d hits, %0d evictions",
             items_sent, cap_writes + 1, results_seen, hits_seen, evictions_seen);
    $display("%0d mismatches found", mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
